@@ sv/msgpack_token_encoder_core_assert.svh @@
// ----------------------------------------------------------------------------
// msgpack_token_encoder_core_assert.svh
// Assertion macros used by mte_byte_ser. Every macro samples on the
// rising edge of i_clk and is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MSGPACK_TOKEN_ENCODER_CORE_ASSERT_SVH
`define MSGPACK_TOKEN_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication: when ANTE holds, CONS holds in that cycle.
`define MTE_ASSERT_NOW(LBL, ANTE, CONS) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ANTE) |-> (CONS)) else $error("mte assertion failed");

// Next-cycle implication: when ANTE holds, CONS holds in the next cycle.
`define MTE_ASSERT_NEXT(LBL, ANTE, CONS) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ANTE) |=> (CONS)) else $error("mte assertion failed");

`endif

@@ sv/mte_pkg.sv @@
// ----------------------------------------------------------------------------
// mte_pkg
// Types, action codes and MessagePack format bytes of the token encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mte_pkg;

    // Token size limits
    localparam int TOKEN_BYTES = 9;
    localparam int TOKEN_W     = 8 * TOKEN_BYTES;
    localparam int CNT_W       = 4;
    localparam int ACTION_W    = 4;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_NIL     = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_BOOL    = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_INT     = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_FLOAT   = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_STR     = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_BIN     = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_ARRAY   = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_MAP     = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_PAYLOAD = 4'd8;

    // Format bytes
    localparam logic [7:0] MP_NIL      = 8'hc0;
    localparam logic [7:0] MP_FALSE    = 8'hc2;
    localparam logic [7:0] MP_TRUE     = 8'hc3;
    localparam logic [7:0] MP_BIN8     = 8'hc4;
    localparam logic [7:0] MP_BIN16    = 8'hc5;
    localparam logic [7:0] MP_BIN32    = 8'hc6;
    localparam logic [7:0] MP_FLOAT64  = 8'hcb;
    localparam logic [7:0] MP_UINT8    = 8'hcc;
    localparam logic [7:0] MP_UINT16   = 8'hcd;
    localparam logic [7:0] MP_UINT32   = 8'hce;
    localparam logic [7:0] MP_UINT64   = 8'hcf;
    localparam logic [7:0] MP_INT8     = 8'hd0;
    localparam logic [7:0] MP_INT16    = 8'hd1;
    localparam logic [7:0] MP_INT32    = 8'hd2;
    localparam logic [7:0] MP_INT64    = 8'hd3;
    localparam logic [7:0] MP_FIXSTR   = 8'ha0;
    localparam logic [7:0] MP_STR8     = 8'hd9;
    localparam logic [7:0] MP_STR16    = 8'hda;
    localparam logic [7:0] MP_STR32    = 8'hdb;
    localparam logic [7:0] MP_FIXARRAY = 8'h90;
    localparam logic [7:0] MP_ARRAY16  = 8'hdc;
    localparam logic [7:0] MP_ARRAY32  = 8'hdd;
    localparam logic [7:0] MP_FIXMAP   = 8'h80;
    localparam logic [7:0] MP_MAP16    = 8'hde;
    localparam logic [7:0] MP_MAP32    = 8'hdf;

    // One input token
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic signed [63:0]  int_value;
        logic [63:0]         float_bits;
        logic [31:0]         length;
        logic                bool_value;
        logic [7:0]          payload_byte;
    } t_item;

    // Encoded token: bytes left-aligned, first byte in the top lane
    typedef struct packed {
        logic [TOKEN_W-1:0] bytes;
        logic [CNT_W-1:0]   cnt;
    } t_token;

endpackage

`default_nettype wire

@@ sv/mte_in_if.sv @@
// ----------------------------------------------------------------------------
// mte_in_if
// Token channel: valid/ready handshake with one MessagePack token per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mte_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic signed [63:0] int_value;
    logic [63:0] float_bits;
    logic [31:0] length;
    logic        bool_value;
    logic [7:0]  payload_byte;

    modport source (
        output valid, action, int_value, float_bits, length, bool_value,
               payload_byte,
        input  ready
    );

    modport sink (
        input  valid, action, int_value, float_bits, length, bool_value,
               payload_byte,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/mte_out_if.sv @@
// ----------------------------------------------------------------------------
// mte_out_if
// Byte channel: valid/ready handshake with one encoded byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (
        output valid, out_byte, last_byte,
        input  ready
    );

    modport sink (
        input  valid, out_byte, last_byte,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/mte_token_enc.sv @@
// ----------------------------------------------------------------------------
// mte_token_enc
// Picks the shortest MessagePack form for one token and lays its bytes out
// left-aligned, with a byte count (zero for an unused action code).
// ----------------------------------------------------------------------------
`default_nettype none

module mte_token_enc (
    input  wire mte_pkg::t_item i_item,
    output mte_pkg::t_token     o_tok
);

    logic [63:0] w_u;
    logic [31:0] w_len;
    logic        w_neg;

    assign w_u   = i_item.int_value;
    assign w_len = i_item.length;
    assign w_neg = w_u[63];

    // Select form and bytes
    always_comb begin
        o_tok.bytes = '0;
        o_tok.cnt   = '0;
        case (i_item.action)
            mte_pkg::ACT_NIL: begin
                o_tok.bytes = {mte_pkg::MP_NIL, 64'd0};
                o_tok.cnt   = 4'd1;
            end
            mte_pkg::ACT_BOOL: begin
                o_tok.bytes = {(i_item.bool_value ? mte_pkg::MP_TRUE : mte_pkg::MP_FALSE),
                               64'd0};
                o_tok.cnt   = 4'd1;
            end
            mte_pkg::ACT_INT: begin
                if (!w_neg) begin
                    if (w_u[63:7] == '0) begin
                        o_tok.bytes = {w_u[7:0], 64'd0};
                        o_tok.cnt   = 4'd1;
                    end else if (w_u[63:8] == '0) begin
                        o_tok.bytes = {mte_pkg::MP_UINT8, w_u[7:0], 56'd0};
                        o_tok.cnt   = 4'd2;
                    end else if (w_u[63:16] == '0) begin
                        o_tok.bytes = {mte_pkg::MP_UINT16, w_u[15:0], 48'd0};
                        o_tok.cnt   = 4'd3;
                    end else if (w_u[63:32] == '0) begin
                        o_tok.bytes = {mte_pkg::MP_UINT32, w_u[31:0], 32'd0};
                        o_tok.cnt   = 4'd5;
                    end else begin
                        o_tok.bytes = {mte_pkg::MP_UINT64, w_u};
                        o_tok.cnt   = 4'd9;
                    end
                end else begin
                    if (&w_u[63:5]) begin
                        o_tok.bytes = {w_u[7:0], 64'd0};
                        o_tok.cnt   = 4'd1;
                    end else if (&w_u[63:7]) begin
                        o_tok.bytes = {mte_pkg::MP_INT8, w_u[7:0], 56'd0};
                        o_tok.cnt   = 4'd2;
                    end else if (&w_u[63:15]) begin
                        o_tok.bytes = {mte_pkg::MP_INT16, w_u[15:0], 48'd0};
                        o_tok.cnt   = 4'd3;
                    end else if (&w_u[63:31]) begin
                        o_tok.bytes = {mte_pkg::MP_INT32, w_u[31:0], 32'd0};
                        o_tok.cnt   = 4'd5;
                    end else begin
                        o_tok.bytes = {mte_pkg::MP_INT64, w_u};
                        o_tok.cnt   = 4'd9;
                    end
                end
            end
            mte_pkg::ACT_FLOAT: begin
                o_tok.bytes = {mte_pkg::MP_FLOAT64, i_item.float_bits};
                o_tok.cnt   = 4'd9;
            end
            mte_pkg::ACT_STR: begin
                if (w_len[31:5] == '0) begin
                    o_tok.bytes = {(mte_pkg::MP_FIXSTR | {3'b000, w_len[4:0]}), 64'd0};
                    o_tok.cnt   = 4'd1;
                end else if (w_len[31:8] == '0) begin
                    o_tok.bytes = {mte_pkg::MP_STR8, w_len[7:0], 56'd0};
                    o_tok.cnt   = 4'd2;
                end else if (w_len[31:16] == '0) begin
                    o_tok.bytes = {mte_pkg::MP_STR16, w_len[15:0], 48'd0};
                    o_tok.cnt   = 4'd3;
                end else begin
                    o_tok.bytes = {mte_pkg::MP_STR32, w_len, 32'd0};
                    o_tok.cnt   = 4'd5;
                end
            end
            mte_pkg::ACT_BIN: begin
                if (w_len[31:8] == '0) begin
                    o_tok.bytes = {mte_pkg::MP_BIN8, w_len[7:0], 56'd0};
                    o_tok.cnt   = 4'd2;
                end else if (w_len[31:16] == '0) begin
                    o_tok.bytes = {mte_pkg::MP_BIN16, w_len[15:0], 48'd0};
                    o_tok.cnt   = 4'd3;
                end else begin
                    o_tok.bytes = {mte_pkg::MP_BIN32, w_len, 32'd0};
                    o_tok.cnt   = 4'd5;
                end
            end
            mte_pkg::ACT_ARRAY: begin
                if (w_len[31:4] == '0) begin
                    o_tok.bytes = {(mte_pkg::MP_FIXARRAY | {4'b0000, w_len[3:0]}),
                                   64'd0};
                    o_tok.cnt   = 4'd1;
                end else if (w_len[31:16] == '0) begin
                    o_tok.bytes = {mte_pkg::MP_ARRAY16, w_len[15:0], 48'd0};
                    o_tok.cnt   = 4'd3;
                end else begin
                    o_tok.bytes = {mte_pkg::MP_ARRAY32, w_len, 32'd0};
                    o_tok.cnt   = 4'd5;
                end
            end
            mte_pkg::ACT_MAP: begin
                if (w_len[31:4] == '0) begin
                    o_tok.bytes = {(mte_pkg::MP_FIXMAP | {4'b0000, w_len[3:0]}), 64'd0};
                    o_tok.cnt   = 4'd1;
                end else if (w_len[31:16] == '0) begin
                    o_tok.bytes = {mte_pkg::MP_MAP16, w_len[15:0], 48'd0};
                    o_tok.cnt   = 4'd3;
                end else begin
                    o_tok.bytes = {mte_pkg::MP_MAP32, w_len, 32'd0};
                    o_tok.cnt   = 4'd5;
                end
            end
            mte_pkg::ACT_PAYLOAD: begin
                o_tok.bytes = {i_item.payload_byte, 64'd0};
                o_tok.cnt   = 4'd1;
            end
            default: begin
                o_tok.bytes = '0;
                o_tok.cnt   = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/mte_byte_ser.sv @@
// ----------------------------------------------------------------------------
// mte_byte_ser
// Result register: holds one encoded token and shifts it out one byte per
// word, flagging the final byte. Reports when it can take the next token.
// ----------------------------------------------------------------------------
`default_nettype none

`include "msgpack_token_encoder_core_assert.svh"

module mte_byte_ser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire mte_pkg::t_token i_tok,
    output logic                 o_free,
    mte_out_if.source            o_out
);

    logic [mte_pkg::TOKEN_W-1:0] r_buf;
    logic [mte_pkg::CNT_W-1:0]   r_cnt;
    logic                        w_take;

    // Drive the byte channel from the top lane
    assign o_out.valid     = (r_cnt != '0);
    assign o_out.out_byte  = r_buf[mte_pkg::TOKEN_W-1 -: 8];
    assign o_out.last_byte = (r_cnt == 4'd1);

    assign w_take = o_out.valid && o_out.ready;
    assign o_free = (r_cnt == '0) || ((r_cnt == 4'd1) && w_take);

    // Load a new token, or advance to the next byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_tok.cnt;
        end else if (w_take) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_tok.bytes;
        end else if (w_take) begin
            r_buf <= {r_buf[mte_pkg::TOKEN_W-9:0], 8'h00};
        end
    end

    // Never overwrite bytes still pending
    `MTE_ASSERT_NOW(a_load_when_free, i_load, o_free)
    // A loaded token has between one and nine bytes
    `MTE_ASSERT_NOW(a_load_cnt, i_load,
        (i_tok.cnt != '0) && (i_tok.cnt <= 4'd9))
    // Each byte taken mid-token drops the count by one
    `MTE_ASSERT_NEXT(a_shift_cnt, w_take && !i_load && (r_cnt > 4'd1),
        r_cnt == $past(r_cnt) - 4'd1)

endmodule

`default_nettype wire

@@ sv/msgpack_token_encoder_core.sv @@
// ----------------------------------------------------------------------------
// msgpack_token_encoder_core
// MessagePack token encoder: one token in, its encoded bytes out.
// ----------------------------------------------------------------------------
// Each token word on i_tok is captured in an input register, encoded to its
// shortest MessagePack form, and placed in a result register that sends 1
// to 9 bytes on o_byte, one byte per cycle while o_byte.ready is high, most
// significant first, with last_byte high on the final one. Throughput is
// set by the byte port: single-byte tokens (payload bytes, fixints, short
// headers) flow at one per cycle while o_byte.ready is high, and while a
// multi-byte token is being sent the next token waits in the input register
// with i_tok.ready low. The first byte is valid on o_byte once the token is
// loaded from the input register into the result register. Unused action
// codes are dropped from the input register and produce no bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module msgpack_token_encoder_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mte_in_if.sink    i_tok,
    mte_out_if.source o_byte
);

    logic            r_in_vld;
    mte_pkg::t_item  r_item;
    mte_pkg::t_token w_tok;
    logic            w_free;
    logic            w_load;
    logic            w_adv;
    logic            w_acc;

    // Hand the held token on when the result register frees up; drop unused codes
    assign w_load      = r_in_vld && (w_tok.cnt != '0) && w_free;
    assign w_adv       = r_in_vld && (w_free || (w_tok.cnt == '0));
    assign i_tok.ready = !r_in_vld || w_adv;
    assign w_acc       = i_tok.valid && i_tok.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item.action       <= i_tok.action;
            r_item.int_value    <= i_tok.int_value;
            r_item.float_bits   <= i_tok.float_bits;
            r_item.length       <= i_tok.length;
            r_item.bool_value   <= i_tok.bool_value;
            r_item.payload_byte <= i_tok.payload_byte;
        end
    end

    mte_token_enc u_enc (
        .i_item (r_item),
        .o_tok  (w_tok)
    );

    mte_byte_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_tok   (w_tok),
        .o_free  (w_free),
        .o_out   (o_byte)
    );

endmodule

`default_nettype wire
